FILE: hw/rtl/wavhc_pkg.sv
// Shared types and constants for the WAV header checker.
package wavhc_pkg;

   localparam int DataWidth = 8;
   localparam int RspWidth  = 120;

   localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
   localparam logic [31:0] TAG_LIST     = 32'h5453_494C;
   localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
   localparam logic [31:0] PCM_FMT_SIZE = 32'd16;
   localparam logic [31:0] PCM_FORMAT   = 32'd1;

   localparam logic [31:0] RESET_RATE     = 32'd44100;
   localparam logic [15:0] RESET_CHANNELS = 16'd1;
   localparam logic [15:0] RESET_BITS     = 16'd16;

   localparam logic [1:0] CSR_RATE     = 2'd0;
   localparam logic [1:0] CSR_CHANNELS = 2'd1;
   localparam logic [1:0] CSR_BITS     = 2'd2;

   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_BAD_RIFF   = 4'd1;
   localparam logic [3:0] ST_BAD_WAVE   = 4'd2;
   localparam logic [3:0] ST_FMT_SIZE   = 4'd3;
   localparam logic [3:0] ST_COMPRESSED = 4'd4;
   localparam logic [3:0] ST_CHANNELS   = 4'd5;
   localparam logic [3:0] ST_RATE       = 4'd6;
   localparam logic [3:0] ST_BITS       = 4'd7;
   localparam logic [3:0] ST_NO_DATA    = 4'd8;

   typedef enum logic [3:0] {
      PH_RIFF, PH_RIFFSIZE, PH_WAVE, PH_FMTTAG, PH_FMTSIZE, PH_FORMAT,
      PH_CHANNELS, PH_RATE, PH_BYTERATE, PH_ALIGN, PH_BITS, PH_TAG,
      PH_LISTSIZE, PH_SKIP, PH_DATASIZE, PH_TAG2
   } phase_type;

   typedef struct packed {
      logic [31:0] rate;
      logic [15:0] channels;
      logic [15:0] bits;
   } cfg_type;

   typedef struct packed {
      logic [31:0] header_length;
      logic [15:0] block_align;
      logic [31:0] byte_rate;
      logic [31:0] data_size;
      logic [3:0]  status;
   } result_type;

endpackage

FILE: hw/rtl/wavhc_parser.sv
// Header parse state and the per-byte field decode and checks.
module wavhc_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic [7:0]                  byte_val,
   input  logic                        file_start,
   input  wavhc_pkg::cfg_type          cfg,
   output logic                        emit,
   output wavhc_pkg::result_type       result
);

   wavhc_pkg::phase_type phase_ff, phase_in, ph;
   logic [1:0]  bif_ff, bif_in, bif;
   logic [23:0] shift_ff, shift_in, shf;
   logic [31:0] skip_ff, skip_in, skip;
   logic [31:0] seen_ff, seen_in, seen;
   logic [31:0] brate_ff, brate_in, brate;
   logic [15:0] align_ff, align_in, align;
   logic        fin_ff, fin_in, fin;
   logic [31:0] word;
   logic        short_field;
   logic        last;

   always_comb begin
      ph    = file_start ? wavhc_pkg::PH_RIFF : phase_ff;
      bif   = file_start ? 2'd0 : bif_ff;
      shf   = file_start ? 24'd0 : shift_ff;
      skip  = file_start ? 32'd0 : skip_ff;
      seen  = file_start ? 32'd0 : seen_ff;
      brate = file_start ? 32'd0 : brate_ff;
      align = file_start ? 16'd0 : align_ff;
      fin   = file_start ? 1'b0 : fin_ff;

      word = {8'd0, shf} | ({24'd0, byte_val} << {bif, 3'b000});
      short_field = (ph == wavhc_pkg::PH_FORMAT) || (ph == wavhc_pkg::PH_CHANNELS) ||
                    (ph == wavhc_pkg::PH_ALIGN) || (ph == wavhc_pkg::PH_BITS);
      last = (bif == 2'd3) || (short_field && bif != 2'd0);

      phase_in = ph;
      bif_in   = bif;
      shift_in = shf;
      skip_in  = skip;
      seen_in  = seen;
      brate_in = brate;
      align_in = align;
      fin_in   = fin;
      emit     = 1'b0;
      result.status    = wavhc_pkg::ST_OK;
      result.data_size = 32'd0;

      if (!fin) begin
         seen_in = (seen == 32'hFFFF_FFFF) ? seen : seen + 32'd1;
         if (ph == wavhc_pkg::PH_SKIP) begin
            skip_in = skip - 32'd1;
            if (skip == 32'd1) phase_in = wavhc_pkg::PH_TAG2;
         end else if (!last) begin
            shift_in = word[23:0];
            bif_in   = bif + 2'd1;
         end else begin
            shift_in = 24'd0;
            bif_in   = 2'd0;
            case (ph)
               wavhc_pkg::PH_RIFF: begin
                  if (word != wavhc_pkg::TAG_RIFF) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_BAD_RIFF;
                  end else phase_in = wavhc_pkg::PH_RIFFSIZE;
               end
               wavhc_pkg::PH_RIFFSIZE: phase_in = wavhc_pkg::PH_WAVE;
               wavhc_pkg::PH_WAVE: begin
                  if (word != wavhc_pkg::TAG_WAVE) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_BAD_WAVE;
                  end else phase_in = wavhc_pkg::PH_FMTTAG;
               end
               wavhc_pkg::PH_FMTTAG: phase_in = wavhc_pkg::PH_FMTSIZE;
               wavhc_pkg::PH_FMTSIZE: begin
                  if (word != wavhc_pkg::PCM_FMT_SIZE) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_FMT_SIZE;
                  end else phase_in = wavhc_pkg::PH_FORMAT;
               end
               wavhc_pkg::PH_FORMAT: begin
                  if (word != wavhc_pkg::PCM_FORMAT) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_COMPRESSED;
                  end else phase_in = wavhc_pkg::PH_CHANNELS;
               end
               wavhc_pkg::PH_CHANNELS: begin
                  if (word != {16'd0, cfg.channels}) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_CHANNELS;
                  end else phase_in = wavhc_pkg::PH_RATE;
               end
               wavhc_pkg::PH_RATE: begin
                  if (word != cfg.rate) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_RATE;
                  end else phase_in = wavhc_pkg::PH_BYTERATE;
               end
               wavhc_pkg::PH_BYTERATE: begin
                  brate_in = word;
                  phase_in = wavhc_pkg::PH_ALIGN;
               end
               wavhc_pkg::PH_ALIGN: begin
                  align_in = word[15:0];
                  phase_in = wavhc_pkg::PH_BITS;
               end
               wavhc_pkg::PH_BITS: begin
                  if (word != {16'd0, cfg.bits}) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_BITS;
                  end else phase_in = wavhc_pkg::PH_TAG;
               end
               wavhc_pkg::PH_TAG: begin
                  if (word == wavhc_pkg::TAG_LIST) phase_in = wavhc_pkg::PH_LISTSIZE;
                  else if (word == wavhc_pkg::TAG_DATA) phase_in = wavhc_pkg::PH_DATASIZE;
                  else begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_NO_DATA;
                  end
               end
               wavhc_pkg::PH_LISTSIZE: begin
                  skip_in  = word;
                  phase_in = (word == 32'd0) ? wavhc_pkg::PH_TAG2 : wavhc_pkg::PH_SKIP;
               end
               wavhc_pkg::PH_TAG2: begin
                  if (word != wavhc_pkg::TAG_DATA) begin
                     emit = 1'b1;
                     result.status = wavhc_pkg::ST_NO_DATA;
                  end else phase_in = wavhc_pkg::PH_DATASIZE;
               end
               wavhc_pkg::PH_DATASIZE: begin
                  emit = 1'b1;
                  result.data_size = word;
               end
               default: ;
            endcase
            if (emit) fin_in = 1'b1;
         end
      end

      result.byte_rate     = brate;
      result.block_align   = align;
      result.header_length = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wavhc_pkg::PH_RIFF;
         bif_ff   <= 2'd0;
         shift_ff <= 24'd0;
         skip_ff  <= 32'd0;
         seen_ff  <= 32'd0;
         brate_ff <= 32'd0;
         align_ff <= 16'd0;
         fin_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         bif_ff   <= bif_in;
         shift_ff <= shift_in;
         skip_ff  <= skip_in;
         seen_ff  <= seen_in;
         brate_ff <= brate_in;
         align_ff <= align_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

FILE: hw/rtl/wavhc_rsp_stage.sv
// Result register driving the response stream.
module wavhc_rsp_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  wavhc_pkg::result_type               result,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wavhc_pkg::RspWidth-1:0]      rsp_tdata
);

   logic                  valid_ff, valid_in;
   wavhc_pkg::result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, data_ff};

endmodule

FILE: hw/rtl/wav_header_checker.sv
// Top level of the WAV header checker.
// A byte is registered, then parsed; the final result is registered to drive rsp_tvalid.
// Throughput: one byte per cycle when not stalled; the parse between input and result register is combinational.
// A byte that ends parsing stalls only while the result register still holds an untaken result.
// Reset (synchronous): parse state cleared, registers at 44100 Hz, 1 channel, 16 bits.
module wav_header_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // data_byte[7:0]
   input  logic          req_tuser,   // file_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[3:0], data_size[35:4], byte_rate[67:36], block_align[83:68],
   // header_length[115:84], zero pad[119:116]
   output logic [119:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   wavhc_pkg::cfg_type    cfg_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_start_ff;
   logic                  emit;
   logic                  fire;
   wavhc_pkg::result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate     <= wavhc_pkg::RESET_RATE;
         cfg_ff.channels <= wavhc_pkg::RESET_CHANNELS;
         cfg_ff.bits     <= wavhc_pkg::RESET_BITS;
      end else if (csr_we) begin
         case (csr_index)
            wavhc_pkg::CSR_RATE:     cfg_ff.rate     <= csr_wdata;
            wavhc_pkg::CSR_CHANNELS: cfg_ff.channels <= csr_wdata[15:0];
            wavhc_pkg::CSR_BITS:     cfg_ff.bits     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign fire       = in_valid_ff && (!emit || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   wavhc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (fire),
      .byte_val   (in_byte_ff),
      .file_start (in_start_ff),
      .cfg        (cfg_ff),
      .emit       (emit),
      .result     (result)
   );

   wavhc_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && emit),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hw/rtl/wavhc_checker.sv
// Port-level checks on the WAV header checker result stream.
module wavhc_checker (
   input logic          clock,
   input logic          reset,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [119:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= wavhc_pkg::ST_NO_DATA)
      else $error("status code out of range");

   a_err_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] != wavhc_pkg::ST_OK |-> rsp_tdata[35:4] == 32'd0)
      else $error("data size set on error status");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == wavhc_pkg::ST_OK |-> rsp_tdata[115:84] >= 32'd44)
      else $error("ok result with short header");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind wav_header_checker wavhc_checker u_wavhc_checker (.*);
